// ----- hw/rtl/signed_int_to_decimal_ascii_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the integer to decimal text converter
// Shared helpers so every checking module reports the same way.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SITDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define SITDA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg
// Types, constants and helpers shared by the converter's controller and
// datapath.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 4;   // digit position 0..9
	localparam int WIDE_W  = 34;  // holds 9 * 10^9

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIZE,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic size;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic neg;
		logic last_digit;
	} status_t;

	// Power of ten for a digit position.
	function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] k);
		logic [WIDE_W-1:0] p;
		case (k)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's-complement integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// One value is taken per beat on the slave side; its text leaves on the
// master side one character per beat: '-' first for a negative value, then
// the digits most significant first with no leading zeros ("0" for zero),
// tlast on the final character. The most negative value is handled through
// its unsigned magnitude. Each value passes a capture step that loads the
// magnitude, a sizing step with a bank of compares against powers of ten,
// then one step per character (1 to 11); the digit unit resolves a
// digit per cycle while the output does not stall, by comparing the
// remaining magnitude with all nine multiples of the current power of ten.
// Output stalls hold the sequencer. The next value is taken once the last
// character has entered the output register.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] character
	output logic        m_axis_tlast
);
	import sitda_pkg::*;

	cmd_t    cmd;
	status_t status;

	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- hw/rtl/sitda_ctrl.sv -----
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: takes a value, sizes it, then steps the datapath through the
// sign and the digits one character at a time.
// ----------------------------------------------------------------------------
module sitda_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sitda_pkg::status_t status,
	output sitda_pkg::cmd_t    cmd
);
	import sitda_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SIZE;
				end
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_d  = status.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (status.slot_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.slot_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/sitda_dp.sv -----
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude register, digit position counter, a bank of compares
// against the multiples of the current power of ten, and the output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module sitda_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sitda_pkg::VALUE_W-1:0]   in_value,
	input  sitda_pkg::cmd_t                 cmd,
	output sitda_pkg::status_t              status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sitda_pkg::CHAR_W-1:0]    out_char,
	output logic                            out_last
);
	import sitda_pkg::*;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [WIDE_W-1:0]  wide_mag;
	logic [WIDE_W-1:0]  pow;
	logic [WIDE_W-1:0]  thr [1:9];
	logic [9:1]         ge;
	logic [POS_W-1:0]   digit;
	logic [WIDE_W-1:0]  sub;
	logic [VALUE_W-1:0] rem;
	logic [POS_W-1:0]   size_cnt;

	always_comb begin
		wide_mag = {{(WIDE_W-VALUE_W){1'b0}}, mag_q};
		pow      = pow10(pos_q);
		digit    = '0;
		sub      = '0;
		size_cnt = '0;
		for (int d = 1; d <= 9; d++) begin
			thr[d] = pow * WIDE_W'(d);
			ge[d]  = wide_mag >= thr[d];
			// thermometer code: the highest multiple that fits wins
			if (ge[d]) begin
				digit = POS_W'(d);
				sub   = thr[d];
			end
			if (wide_mag >= pow10(POS_W'(d))) begin
				size_cnt = size_cnt + POS_W'(1);
			end
		end
		rem = VALUE_W'(wide_mag - sub);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= in_value[VALUE_W-1] ? VALUE_W'(VALUE_W'(0) - in_value) : in_value;
			neg_q <= in_value[VALUE_W-1];
		end
		if (cmd.size) begin
			pos_q <= size_cnt;
		end
		if (cmd.emit_digit) begin
			mag_q <= rem;
			if (pos_q != '0) begin
				pos_q <= pos_q - POS_W'(1);
			end
		end
		if (cmd.emit_sign) begin
			out_char_q <= ASCII_MINUS;
			out_last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			out_char_q <= ASCII_ZERO + CHAR_W'(digit);
			out_last_q <= (pos_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.slot_free  = !out_valid_q || out_ready;
	assign status.neg        = neg_q;
	assign status.last_digit = (pos_q == '0);

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	`SITDA_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.size, cmd.emit_sign, cmd.emit_digit}), "more than one datapath command")
	`SITDA_ASSERT(a_emit_free, ((cmd.emit_sign || cmd.emit_digit) |-> status.slot_free), "character emitted over a pending beat")
	`SITDA_ASSERT(a_sign_neg, (cmd.emit_sign |-> neg_q), "sign emitted for a non-negative value")
	`SITDA_ASSERT_NEXT(a_char_legal, (cmd.emit_sign || cmd.emit_digit), ((out_char_q == ASCII_MINUS && !out_last_q) || (out_char_q >= ASCII_ZERO && out_char_q <= ASCII_NINE)), "illegal output character")

endmodule

// ----- verif/tb_signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Streams signed 32-bit values into the decimal text converter and checks
// every character beat and its tlast against a local digit expansion of the
// same value. Directed corner values come first, then random values spread
// over every digit count and sign, a burst with both sides held busy, and
// raw random words. Both stream sides idle at random outside the burst.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
	timeunit 1ns;
	timeprecision 1ps;

	import sitda_pkg::*;

	typedef struct {
		logic [CHAR_W-1:0]  code;
		logic               last;
		logic [VALUE_W-1:0] source;
	} text_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata = '0;   // [31:0] value
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [7:0]         m_axis_tdata;        // [7:0] character
	logic               m_axis_tlast;

	text_char_t pending_text[$];
	int         mismatch_count = 0;
	bit         free_flow = 1'b0;

	signed_int_to_decimal_ascii uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Expand a value into its decimal characters and queue them.
	function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw);
		logic              negative;
		logic [VALUE_W-1:0] magnitude;
		logic [3:0]        digit_buf[10];
		int                ndigits;
		text_char_t        ch;
		negative = raw[VALUE_W-1];
		magnitude = negative ? (~raw + 1'b1) : raw;
		ndigits = 0;
		do begin
			digit_buf[ndigits] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			ndigits++;
		end while (magnitude != 0 && ndigits < 10);
		ch.source = raw;
		if (negative) begin
			ch.code = ASCII_MINUS;
			ch.last = 1'b0;
			pending_text.push_back(ch);
		end
		for (int k = ndigits - 1; k >= 0; k--) begin
			ch.code = ASCII_ZERO + CHAR_W'(digit_buf[k]);
			ch.last = (k == 0);
			pending_text.push_back(ch);
		end
	endfunction

	// Random stall on the character side, none during the burst.
	always @(posedge clk) begin
		m_axis_tready <= free_flow ? 1'b1 : ($urandom_range(0, 99) >= 17);
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected character beat: expected none, actual %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				want = pending_text.pop_front();
				if (m_axis_tdata !== want.code) begin
					$display("%0t: value %0d character: expected %h, actual %h",
						$time, $signed(want.source), want.code, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: value %0d tlast: expected %b, actual %b",
						$time, $signed(want.source), want.last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Offer one value, with random idle cycles first unless in a burst.
	task automatic send_value(input logic [VALUE_W-1:0] value);
		while (!free_flow && $urandom_range(0, 99) < 17) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		queue_decimal_text(value);
	endtask

	// Pick a value with the given digit count and sign.
	function automatic logic [VALUE_W-1:0] value_with_digits(input int ndigits,
			input bit negative);
		longint lo, hi, mag;
		lo = 1;
		for (int i = 1; i < ndigits; i++) lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndigits == 1) lo = 0;
		if (negative && hi > 64'sd2147483648) hi = 64'sd2147483648;
		if (!negative && hi > 64'sd2147483647) hi = 64'sd2147483647;
		mag = lo + (longint'($urandom) % (hi - lo + 1));
		return negative ? VALUE_W'(-mag) : VALUE_W'(mag);
	endfunction

	task automatic test_corner_values();
		logic [VALUE_W-1:0] corners[$];
		corners = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd100, 32'd2147483647, 32'h80000000, -32'sd2147483647,
			32'd1000000000, 32'd999999999, -32'sd1000000000, -32'sd999999999,
			32'd1999999999, 32'd1234567890, -32'sd1234567890, 32'h55555555,
			32'hAAAAAAAA, 32'd7, -32'sd9};
		foreach (corners[i]) send_value(corners[i]);
	endtask

	task automatic test_digit_counts(input int count);
		repeat (count) send_value(value_with_digits($urandom_range(1, 10),
			1'($urandom_range(0, 1))));
	endtask

	task automatic test_raw_words(input int count);
		repeat (count) send_value($urandom);
	endtask

	// Hold both sides busy with no idling at all.
	task automatic test_back_to_back(input int count);
		free_flow = 1'b1;
		repeat (count) begin
			if ($urandom_range(0, 1)) send_value($urandom);
			else send_value(value_with_digits($urandom_range(1, 10),
				1'($urandom_range(0, 1))));
		end
		free_flow = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_digit_counts(200);
		test_back_to_back(60);
		test_raw_words(100);
		s_axis_tvalid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_text.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
